@@ hdl/sm4c_pkg.sv @@
// sm4c_pkg: shared types, constants and tables for the sm4 cbc encryption core
// holds the s-box, system parameters fk/ck, register indexes and sequencer states
// no dependencies
`default_nettype none

package sm4c_pkg;

	localparam int ROUNDS = 32;
	localparam int CNT_W  = $clog2(ROUNDS);
	localparam logic [CNT_W-1:0] LAST_ROUND = CNT_W'(ROUNDS - 1);

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IV_HIGH  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IV_LOW   = 2'd3;

	// sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_EXPAND,
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	// key schedule system parameter
	localparam logic [31:0] FK [4] = '{
		32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
	};

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic logic [7:0] sbox(input logic [7:0] b);
		return SBOX[b];
	endfunction

	// ck word i: byte j is (4*i + j) * 7 mod 256
	function automatic logic [31:0] ck_word(input logic [CNT_W-1:0] i);
		logic [31:0] w;
		logic [7:0]  idx;
		w = '0;
		for (int j = 0; j < 4; j++) begin
			idx = {1'b0, i, 2'(j)};
			w[31-8*j -: 8] = 8'(idx * 8'd7);
		end
		return w;
	endfunction

endpackage

`default_nettype wire

@@ hdl/sm4c_round.sv @@
// sm4c_round: the single sm4 round unit shared by key expansion and encryption
// computes x0 ^ L(S(x1 ^ x2 ^ x3 ^ k)), with L' in key mode
// depends on sm4c_pkg
`default_nettype none

module sm4c_round
	import sm4c_pkg::*;
(
	input  wire logic [127:0] word,
	input  wire logic [31:0]  rkey,
	input  wire logic         key_mode,
	output logic [31:0]       new_word
);

	logic [31:0] x0, x1, x2, x3;
	logic [31:0] mix;
	logic [31:0] sub;
	logic [31:0] lin_enc;
	logic [31:0] lin_key;

	assign x0 = word[127:96];
	assign x1 = word[95:64];
	assign x2 = word[63:32];
	assign x3 = word[31:0];

	// nonlinear layer
	assign mix = x1 ^ x2 ^ x3 ^ rkey;
	assign sub = {sbox(mix[31:24]), sbox(mix[23:16]), sbox(mix[15:8]), sbox(mix[7:0])};

	// linear layers: rotations 2,10,18,24 for data, 13,23 for the key schedule
	assign lin_enc = sub ^ {sub[29:0], sub[31:30]} ^ {sub[21:0], sub[31:22]}
		^ {sub[13:0], sub[31:14]} ^ {sub[7:0], sub[31:8]};
	assign lin_key = sub ^ {sub[18:0], sub[31:19]} ^ {sub[8:0], sub[31:9]};

	assign new_word = x0 ^ (key_mode ? lin_key : lin_enc);

endmodule

`default_nettype wire

@@ hdl/sm4c_rk_ram.sv @@
// sm4c_rk_ram: round key store, one write and one registered read port
// depends on sm4c_pkg
`default_nettype none

module sm4c_rk_ram
	import sm4c_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [CNT_W-1:0] waddr,
	input  wire logic [31:0]      wdata,
	input  wire logic [CNT_W-1:0] raddr,
	output logic [31:0]           rdata
);

	logic [31:0] mem [ROUNDS];
	logic [31:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ hdl/sm4c_cbc_top_dummy_placeholder.sv @@
// sm4c_seq: sequencer for key expansion and block encryption rounds
// decodes state, round counter and output slot into datapath controls
// depends on sm4c_pkg
`default_nettype none

module sm4c_seq
	import sm4c_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             key_write,
	input  wire logic             out_free,
	output logic                  in_stall,
	output logic                  ld_key,
	output logic                  ld_blk,
	output logic                  shift,
	output logic                  key_mode,
	output logic                  fin,
	output logic                  fin_now,
	output logic [CNT_W-1:0]      cnt,
	output logic [CNT_W-1:0]      rd_addr
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;

	// state and round counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ld_key || ld_blk) begin
				cnt_q <= '0;
			end else if (shift) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// next state and controls
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		ld_key   = 1'b0;
		ld_blk   = 1'b0;
		shift    = 1'b0;
		key_mode = 1'b0;
		fin      = 1'b0;
		fin_now  = 1'b0;
		rd_addr  = '0;
		unique case (state_q)
			ST_LOAD: begin
				ld_key  = 1'b1;
				state_d = ST_EXPAND;
			end
			ST_EXPAND: begin
				shift    = 1'b1;
				key_mode = 1'b1;
				if (cnt_q == LAST_ROUND) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = key_write;
				if (in_valid && !key_write) begin
					ld_blk  = 1'b1;
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				shift   = 1'b1;
				rd_addr = cnt_q + 1'b1;
				if (cnt_q == LAST_ROUND) begin
					if (out_free) begin
						fin     = 1'b1;
						fin_now = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_LOAD;
		endcase
		// a key write restarts the schedule from the new key
		if (key_write) begin
			state_d = ST_LOAD;
		end
	end

	assign cnt = cnt_q;

endmodule

`default_nettype wire

@@ hdl/sm4_cbc_encrypt_core.sv @@
// sm4_cbc_encrypt_core: top level of the sm4 cbc encryption core
// depends on sm4c_pkg, sm4c_round, sm4c_rk_ram, sm4c_seq
//
// Encrypts one 128-bit block per input beat with SM4 in CBC mode. One round
// unit does all the work: after reset and after every write of key_high or
// key_low it expands the 32 round keys into a small key store, during which
// in_stall is high (configuration writes are still taken). A block is XORed
// with the IV (start_chain set, or no block since reset) or the previous
// ciphertext at the accepting edge, then runs 32 rounds at one round per cycle
// through the same unit; the next block is accepted only after it finishes.
// The ciphertext sits in an output register; if that register is still held
// by a stalled earlier beat, the finished block waits until it frees. IV
// writes only take effect for the next block that uses the IV.
`default_nettype none

module sm4_cbc_encrypt_core
	import sm4c_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]          cfg_data,
	// input channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [63:0]          plain_high,
	input  wire logic [63:0]          plain_low,
	input  wire logic                 start_chain,
	// output channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [63:0]               cipher_high,
	output logic [63:0]               cipher_low
);

	logic [63:0]       key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic [127:0]      word_q;
	logic [127:0]      word_next;
	logic [127:0]      fin_word;
	logic [127:0]      chain_q;
	logic              started_q;
	logic [63:0]       cipher_high_q, cipher_low_q;
	logic              out_valid_q;
	logic              key_write;
	logic              out_free;
	logic              ld_key, ld_blk, shift, key_mode, fin, fin_now;
	logic [CNT_W-1:0]  cnt, rd_addr;
	logic [31:0]       rk_rdata;
	logic [31:0]       rkey;
	logic [31:0]       new_word;
	logic              use_iv;
	logic [127:0]      chain_sel;

	assign key_write = cfg_we && (cfg_index == CFG_KEY_HIGH || cfg_index == CFG_KEY_LOW);
	assign out_free  = !out_valid_q || !out_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			iv_high_q  <= '0;
			iv_low_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_HIGH: key_high_q <= cfg_data;
				CFG_KEY_LOW:  key_low_q  <= cfg_data;
				CFG_IV_HIGH:  iv_high_q  <= cfg_data;
				CFG_IV_LOW:   iv_low_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	sm4c_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.key_write(key_write),
		.out_free (out_free),
		.in_stall (in_stall),
		.ld_key   (ld_key),
		.ld_blk   (ld_blk),
		.shift    (shift),
		.key_mode (key_mode),
		.fin      (fin),
		.fin_now  (fin_now),
		.cnt      (cnt),
		.rd_addr  (rd_addr)
	);

	// shared round unit
	assign rkey = key_mode ? ck_word(cnt) : rk_rdata;

	sm4c_round u_round (
		.word    (word_q),
		.rkey    (rkey),
		.key_mode(key_mode),
		.new_word(new_word)
	);

	sm4c_rk_ram u_rk_ram (
		.clk  (clk),
		.we   (shift && key_mode),
		.waddr(cnt),
		.wdata(new_word),
		.raddr(rd_addr),
		.rdata(rk_rdata)
	);

	// chaining value select
	assign use_iv    = start_chain || !started_q;
	assign chain_sel = use_iv ? {iv_high_q, iv_low_q} : chain_q;

	// working word register shared by key schedule and rounds
	assign word_next = {word_q[95:0], new_word};

	always_ff @(posedge clk) begin
		if (ld_key) begin
			word_q <= {key_high_q[63:32] ^ FK[0], key_high_q[31:0] ^ FK[1],
				key_low_q[63:32] ^ FK[2], key_low_q[31:0] ^ FK[3]};
		end else if (ld_blk) begin
			word_q <= {plain_high, plain_low} ^ chain_sel;
		end else if (shift) begin
			word_q <= word_next;
		end
	end

	// final words leave in reverse order
	assign fin_word = fin_now ? word_next : word_q;

	always_ff @(posedge clk) begin
		if (fin) begin
			cipher_high_q <= {fin_word[31:0], fin_word[63:32]};
			cipher_low_q  <= {fin_word[95:64], fin_word[127:96]};
			chain_q       <= {fin_word[31:0], fin_word[63:32],
				fin_word[95:64], fin_word[127:96]};
		end
	end

	// output beat valid and chain status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			started_q   <= 1'b0;
		end else begin
			if (fin) begin
				out_valid_q <= 1'b1;
				started_q   <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign cipher_high = cipher_high_q;
	assign cipher_low  = cipher_low_q;

endmodule

`default_nettype wire

@@ tb/sm4_cbc_encrypt_core_test.sv @@
// sm4_cbc_encrypt_core_test: self-checking testbench for the sm4 cbc encryption core
// drives random-gap beats into sm4_cbc_encrypt_core and checks every ciphertext beat
// against an in-bench sm4 cbc predictor; depends on sm4c_pkg and the core rtl
`timescale 1ns / 1ps

module sm4_cbc_encrypt_core_test;
	import sm4c_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RAND_PHASES  = 10;
	localparam int PHASE_BEATS  = 85;
	localparam int MAX_REPORTS  = 10;

	localparam logic [CFG_IDX_W-1:0] REG_ORDER [4] = '{
		CFG_KEY_HIGH, CFG_KEY_LOW, CFG_IV_HIGH, CFG_IV_LOW
	};

	// sm4 system parameter and s-box
	localparam logic [31:0] sys_fk [4] = '{
		32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc
	};

	localparam logic [7:0] sbox_lut [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	// directed stimulus table: register writes and blocks, some with known ciphertext
	typedef enum logic { ROW_CFG, ROW_BLK } row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [63:0]            a;      // plain_high or register data
		logic [63:0]            b;      // plain_low
		logic                   sc;     // start_chain
		logic                   known;  // ct below is the expected ciphertext
		logic [127:0]           ct;
	} dir_row_t;

	localparam logic [63:0] STD_HI = 64'h0123456789abcdef;
	localparam logic [63:0] STD_LO = 64'hfedcba9876543210;
	localparam logic [127:0] STD_CT = 128'h681edf34d206965e86b3e94f536e4246;
	localparam logic [63:0] ONES = 64'hffffffffffffffff;
	localparam logic [63:0] ZERO = 64'h0;

	localparam int DIR_ROWS = 24;
	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		// zero key after reset, no chain yet so the iv is used with start_chain low
		'{ROW_BLK, '0, ZERO, ZERO, 1'b0, 1'b0, '0},
		'{ROW_BLK, '0, ONES, ONES, 1'b0, 1'b0, '0},
		'{ROW_BLK, '0, ZERO, ZERO, 1'b1, 1'b0, '0},
		// standard key, zero iv gives the standard vector
		'{ROW_CFG, CFG_KEY_HIGH, STD_HI, ZERO, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_KEY_LOW,  STD_LO, ZERO, 1'b0, 1'b0, '0},
		'{ROW_BLK, '0, STD_HI, STD_LO, 1'b1, 1'b1, STD_CT},
		'{ROW_BLK, '0, STD_HI, STD_LO, 1'b0, 1'b0, '0},
		// iv write leaves the running chain alone
		'{ROW_CFG, CFG_IV_HIGH, ONES, ZERO, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_IV_LOW,  ONES, ZERO, 1'b0, 1'b0, '0},
		'{ROW_BLK, '0, STD_HI, STD_LO, 1'b0, 1'b0, '0},
		// all-ones iv inverts the block back into the standard plaintext
		'{ROW_BLK, '0, STD_LO, STD_HI, 1'b1, 1'b1, STD_CT},
		'{ROW_BLK, '0, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 1'b0, '0},
		// key change in the middle of a chain
		'{ROW_CFG, CFG_KEY_HIGH, ONES, ZERO, 1'b0, 1'b0, '0},
		'{ROW_BLK, '0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_KEY_LOW, ONES, ZERO, 1'b0, 1'b0, '0},
		'{ROW_BLK, '0, ONES, ONES, 1'b0, 1'b0, '0},
		'{ROW_BLK, '0, ZERO, ZERO, 1'b1, 1'b0, '0},
		'{ROW_CFG, CFG_IV_HIGH, ZERO, ZERO, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_IV_LOW,  ZERO, ZERO, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_KEY_HIGH, STD_HI, ZERO, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_KEY_LOW,  STD_LO, ZERO, 1'b0, 1'b0, '0},
		'{ROW_BLK, '0, STD_HI, STD_LO, 1'b1, 1'b1, STD_CT},
		'{ROW_BLK, '0, 64'h8000000000000000, 64'h0000000000000001, 1'b0, 1'b0, '0},
		'{ROW_BLK, '0, ONES, ZERO, 1'b1, 1'b0, '0}
	};

	// clock, reset and dut ports
	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index   = '0;
	logic [63:0]          cfg_data    = '0;
	logic                 in_valid    = 1'b0;
	logic [63:0]          plain_high  = '0;
	logic [63:0]          plain_low   = '0;
	logic                 start_chain = 1'b0;
	logic                 out_stall   = 1'b0;
	logic                 in_stall;
	logic                 out_valid;
	logic [63:0]          cipher_high;
	logic [63:0]          cipher_low;

	sm4_cbc_encrypt_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.plain_high  (plain_high),
		.plain_low   (plain_low),
		.start_chain (start_chain),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cipher_high (cipher_high),
		.cipher_low  (cipher_low)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state: registers, chain and round keys
	logic [63:0]  key_hi_m   = '0;
	logic [63:0]  key_lo_m   = '0;
	logic [63:0]  iv_hi_m    = '0;
	logic [63:0]  iv_lo_m    = '0;
	logic [63:0]  chain_hi_m = '0;
	logic [63:0]  chain_lo_m = '0;
	logic         chain_seen = 1'b0;
	logic [31:0]  rk_tab [32];

	logic [127:0] ct_q [$];
	int           mism_cnt = 0;
	int           cycle_cnt = 0;
	logic         calm_in = 1'b0;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [31:0] tau(input logic [31:0] x);
		return {sbox_lut[x[31:24]], sbox_lut[x[23:16]], sbox_lut[x[15:8]], sbox_lut[x[7:0]]};
	endfunction

	// key schedule; ck byte j of word i is (4i+j)*7 mod 256
	function automatic void expand_round_keys();
		logic [31:0] k [4];
		logic [31:0] ck;
		logic [31:0] b;
		logic [31:0] rk;
		k[0] = key_hi_m[63:32] ^ sys_fk[0];
		k[1] = key_hi_m[31:0]  ^ sys_fk[1];
		k[2] = key_lo_m[63:32] ^ sys_fk[2];
		k[3] = key_lo_m[31:0]  ^ sys_fk[3];
		for (int i = 0; i < 32; i++) begin
			for (int j = 0; j < 4; j++)
				ck[31-8*j -: 8] = 8'((4 * i + j) * 7);
			b = tau(k[(i + 1) % 4] ^ k[(i + 2) % 4] ^ k[(i + 3) % 4] ^ ck);
			rk = k[i % 4] ^ b ^ rotl(b, 13) ^ rotl(b, 23);
			rk_tab[i] = rk;
			k[i % 4] = rk;
		end
	endfunction

	function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		case (idx)
			CFG_KEY_HIGH: begin
				key_hi_m = val;
				expand_round_keys();
			end
			CFG_KEY_LOW: begin
				key_lo_m = val;
				expand_round_keys();
			end
			CFG_IV_HIGH: iv_hi_m = val;
			CFG_IV_LOW:  iv_lo_m = val;
			default: ;
		endcase
	endfunction

	// one cbc block: xor with iv or previous ciphertext, 32 rounds, reversed words
	function automatic logic [127:0] encrypt_block(input logic [63:0] ph, input logic [63:0] pl,
			input logic sc);
		logic [31:0] x [4];
		logic [31:0] b;
		logic [63:0] hi;
		logic [63:0] lo;
		logic        use_iv;
		use_iv = sc || !chain_seen;
		hi = ph ^ (use_iv ? iv_hi_m : chain_hi_m);
		lo = pl ^ (use_iv ? iv_lo_m : chain_lo_m);
		x[0] = hi[63:32];
		x[1] = hi[31:0];
		x[2] = lo[63:32];
		x[3] = lo[31:0];
		for (int i = 0; i < 32; i++) begin
			b = tau(x[(i + 1) % 4] ^ x[(i + 2) % 4] ^ x[(i + 3) % 4] ^ rk_tab[i]);
			x[i % 4] = x[i % 4] ^ b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
		end
		hi = {x[3], x[2]};
		lo = {x[1], x[0]};
		chain_hi_m = hi;
		chain_lo_m = lo;
		chain_seen = 1'b1;
		return {hi, lo};
	endfunction

	// random 64-bit value, now and then an extreme
	function automatic logic [63:0] rand_data();
		int roll;
		roll = $urandom_range(0, 7);
		if (roll == 0)
			return ZERO;
		else if (roll == 1)
			return ONES;
		return {$urandom, $urandom};
	endfunction

	// send one input beat after a random gap, record its expected ciphertext
	task automatic send_block(input logic [63:0] ph, input logic [63:0] pl, input logic sc,
			input logic known, input logic [127:0] ct);
		int gap;
		int roll;
		logic [127:0] pred;
		roll = $urandom_range(0, 99);
		if (calm_in || roll < 55)
			gap = 0;
		else if (roll < 85)
			gap = $urandom_range(1, 3);
		else if (roll < 97)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(20, 80);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		plain_high  <= ph;
		plain_low   <= pl;
		start_chain <= sc;
		do
			@(posedge clk);
		while (in_stall);
		pred = encrypt_block(ph, pl, sc);
		ct_q.push_back(known ? ct : pred);
	endtask

	// stop sending and let every outstanding block come out
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (ct_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		apply_config(idx, val);
	endtask

	task automatic note_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		mism_cnt++;
		if (mism_cnt <= MAX_REPORTS)
			$display("mismatch on %s: expected %h, got %h", what, want, got);
	endtask

	// receiver stall: segments of random length, a few long, some calm stretches
	int   stall_len = 0;
	int   stall_roll;
	logic stall_val = 1'b0;

	always @(negedge clk) begin
		if (stall_len == 0) begin
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 8) begin
				stall_val = 1'b0;
				stall_len = $urandom_range(50, 300);
			end else if (stall_roll < 55) begin
				stall_val = 1'b0;
				stall_len = $urandom_range(1, 4);
			end else if (stall_roll < 88) begin
				stall_val = 1'b1;
				stall_len = $urandom_range(1, 3);
			end else if (stall_roll < 98) begin
				stall_val = 1'b1;
				stall_len = $urandom_range(4, 12);
			end else begin
				stall_val = 1'b1;
				stall_len = $urandom_range(20, 80);
			end
		end
		stall_len = stall_len - 1;
		out_stall <= stall_val;
	end

	// output beat check against the oldest expected ciphertext
	logic [127:0] want_ct;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (ct_q.size() == 0) begin
				note_mismatch("unexpected beat", '0, cipher_high);
			end else begin
				want_ct = ct_q.pop_front();
				if (cipher_high !== want_ct[127:64])
					note_mismatch("cipher_high", want_ct[127:64], cipher_high);
				if (cipher_low !== want_ct[63:0])
					note_mismatch("cipher_low", want_ct[63:0], cipher_low);
			end
		end
	end

	// run limit
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// main sequence: reset, directed table, random phases, end
	initial begin
		int   left;
		int   len;
		logic sc;
		logic first;
		expand_round_keys();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (DIR_TAB[r].kind == ROW_CFG)
				write_reg(DIR_TAB[r].idx, DIR_TAB[r].a);
			else
				send_block(DIR_TAB[r].a, DIR_TAB[r].b, DIR_TAB[r].sc,
					DIR_TAB[r].known, DIR_TAB[r].ct);
		end

		for (int p = 0; p < RAND_PHASES; p++) begin
			// new key and iv: all zero, then all ones, then random subsets
			for (int r = 0; r < 4; r++) begin
				if (p < 2 || $urandom_range(0, 3) != 0)
					write_reg(REG_ORDER[r], (p == 0) ? ZERO : (p == 1) ? ONES : rand_data());
			end
			left = PHASE_BEATS;
			first = 1'b1;
			while (left > 0) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
				calm_in = ($urandom_range(0, 5) == 0);
				for (int k = 0; k < len && left > 0; k++) begin
					// a message opens with start_chain (a phase's first now and then without); stray restarts inside as noise
					if (k == 0)
						sc = !(first && $urandom_range(0, 2) == 0);
					else
						sc = ($urandom_range(0, 24) == 0);
					send_block(rand_data(), rand_data(), sc, 1'b0, '0);
					left--;
					first = 1'b0;
				end
				if ($urandom_range(0, 15) == 0)
					drain();
			end
		end

		calm_in = 1'b0;
		drain();
		if (mism_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
